// ===== hdl/crw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crw_pkg;

  // Keyword window depth and derived widths
  localparam int KEYWORD_MAX = 16;
  localparam int WIN_IDX_W   = (KEYWORD_MAX > 1) ? $clog2(KEYWORD_MAX) : 1;
  localparam int FILL_W      = $clog2(KEYWORD_MAX + 1);
  localparam int KW_BYTES    = 16;
  localparam int KW_IDX_W    = $clog2(KW_BYTES);
  localparam int KLEN_W      = 5;

  // Register file layout
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EV_SEND = 2'd0,
    EV_OK   = 2'd1,
    EV_FAIL = 2'd2
  } evt_t;

  typedef enum logic [2:0] {
    REG_KW_LOW       = 3'd0,
    REG_KW_HIGH      = 3'd1,
    REG_KW_LENGTH    = 3'd2,
    REG_RETRY_LIMIT  = 3'd3,
    REG_TIMEOUT      = 3'd4,
    REG_CHECK_PERIOD = 3'd5
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== hdl/command_response_watcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command/response watcher. A start transaction opens an exchange and yields a
// send-command result (or an immediate failure when retry_limit is zero);
// received-byte transactions feed a keyword window, and tick transactions drive
// the per-attempt timeout and the periodic success check. The block takes one
// transaction per clock while the output is not stalled: each one is captured
// in an input register, handled in a single pass through the parallel keyword
// compare and the tick counters, and any result is then captured in the output
// register. A stalled result holds the output register while one more
// transaction waits in the input register; in_stall rises only when both are
// occupied. Registers sit at byte address 8*i on the 64-bit APB-style port and
// should be written while no transaction is in flight.
module command_response_watcher (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [7:0]                      in_rx_byte,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_event_res,
  output logic [7:0]                           out_attempts_left,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [crw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [crw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [crw_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int WIN_N  = crw_pkg::KEYWORD_MAX;
  localparam int FILL_W = crw_pkg::FILL_W;
  localparam int KLEN_W = crw_pkg::KLEN_W;

  // Configuration registers
  logic [63:0]       kw_low_r;
  logic [63:0]       kw_high_r;
  logic [KLEN_W-1:0] kw_len_r;
  logic [7:0]        retry_limit_r;
  logic [15:0]       timeout_r;
  logic [15:0]       check_period_r;

  // Input register
  logic       in_valid_r;
  logic [1:0] in_kind_r;
  logic [7:0] in_byte_r;

  // Exchange state
  logic [7:0]        win_r [WIN_N];
  logic [7:0]        win_nxt [WIN_N];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              seen_r, seen_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [15:0]       phase_r, phase_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic              busy_r, busy_nxt;

  // Output register
  logic                out_valid_r;
  crw_pkg::evt_t       out_event_r;
  logic [7:0]          out_left_r;

  logic                res_valid;
  crw_pkg::evt_t       res_event;
  logic [7:0]          res_left;

  logic advance;
  logic fire;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  // Window compare signals
  logic [7:0]        win_sh [WIN_N];
  logic [FILL_W-1:0] fill_inc;
  logic [KLEN_W-1:0] kw_n;
  logic [127:0]      kw_all;
  logic [WIN_N-1:0]  pos_eq;
  logic              tail_match;

  // Tick arithmetic
  logic [16:0] tick_inc;
  logic [16:0] phase_inc;
  logic [7:0]  rem_dec;

  // Handshake: the pipeline moves whenever the output register is empty or not stalled
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_event_res     = out_event_r;
  assign out_attempts_left = out_left_r;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    case (cfg_idx)
      crw_pkg::REG_KW_LOW:       prdata = kw_low_r;
      crw_pkg::REG_KW_HIGH:      prdata = kw_high_r;
      crw_pkg::REG_KW_LENGTH:    prdata = {{(64-KLEN_W){1'b0}}, kw_len_r};
      crw_pkg::REG_RETRY_LIMIT:  prdata = {56'd0, retry_limit_r};
      crw_pkg::REG_TIMEOUT:      prdata = {48'd0, timeout_r};
      crw_pkg::REG_CHECK_PERIOD: prdata = {48'd0, check_period_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_low_r       <= '0;
      kw_high_r      <= '0;
      kw_len_r       <= KLEN_W'(2);
      retry_limit_r  <= 8'd3;
      timeout_r      <= 16'd1000;
      check_period_r <= 16'd10;
    end else if (cfg_wr) begin
      case (cfg_idx)
        crw_pkg::REG_KW_LOW:       kw_low_r       <= pwdata;
        crw_pkg::REG_KW_HIGH:      kw_high_r      <= pwdata;
        crw_pkg::REG_KW_LENGTH:    kw_len_r       <= pwdata[KLEN_W-1:0];
        crw_pkg::REG_RETRY_LIMIT:  retry_limit_r  <= pwdata[7:0];
        crw_pkg::REG_TIMEOUT:      timeout_r      <= pwdata[15:0];
        crw_pkg::REG_CHECK_PERIOD: check_period_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_kind_r <= in_kind;
      in_byte_r <= in_rx_byte;
    end
  end

  // Keyword compare on the window as it stands after shifting in the new byte
  assign kw_all = {kw_high_r, kw_low_r};
  assign kw_n   = (kw_len_r > KLEN_W'(WIN_N)) ? KLEN_W'(WIN_N) : kw_len_r;
  assign fill_inc = (fill_r == FILL_W'(WIN_N)) ? fill_r : fill_r + FILL_W'(1);

  always_comb begin
    logic [KLEN_W-1:0]           kidx;
    logic [crw_pkg::KW_IDX_W-1:0] bidx;
    kidx = '0;
    bidx = '0;
    for (int j = 0; j < WIN_N; j++) begin
      win_sh[j] = (j == 0) ? in_byte_r : win_r[(j == 0) ? 0 : j - 1];
    end
    for (int j = 0; j < WIN_N; j++) begin
      // newest byte pairs with the last keyword byte
      kidx = kw_n - KLEN_W'(1) - KLEN_W'(j);
      bidx = kidx[crw_pkg::KW_IDX_W-1:0];
      pos_eq[j] = (KLEN_W'(j) >= kw_n) || (win_sh[j] == kw_all[{bidx, 3'b000} +: 8]);
    end
    tail_match = (KLEN_W'(fill_inc) >= kw_n) && (&pos_eq);
  end

  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign phase_inc = {1'b0, phase_r} + 17'd1;
  assign rem_dec   = (rem_r != 8'd0) ? rem_r - 8'd1 : rem_r;

  // Exchange control: one pass per transaction
  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    seen_nxt  = seen_r;
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    busy_nxt  = busy_r;
    res_valid = 1'b0;
    res_event = crw_pkg::EV_SEND;
    res_left  = 8'd0;

    if (fire) begin
      case (in_kind_r)
        crw_pkg::KIND_START: begin
          fill_nxt  = '0;
          seen_nxt  = 1'b0;
          tick_nxt  = '0;
          phase_nxt = '0;
          res_valid = 1'b1;
          if (retry_limit_r == 8'd0) begin
            rem_nxt   = 8'd0;
            busy_nxt  = 1'b0;
            res_event = crw_pkg::EV_FAIL;
          end else begin
            rem_nxt   = retry_limit_r;
            busy_nxt  = 1'b1;
            res_event = crw_pkg::EV_SEND;
            res_left  = retry_limit_r;
          end
        end
        crw_pkg::KIND_BYTE: begin
          if (busy_r) begin
            win_nxt  = win_sh;
            fill_nxt = fill_inc;
            if (tail_match) begin
              seen_nxt = 1'b1;
            end
          end
        end
        crw_pkg::KIND_TICK: begin
          if (busy_r) begin
            tick_nxt = tick_inc[15:0];
            if (tick_inc >= {1'b0, timeout_r}) begin
              // attempt timed out: retry or give up
              rem_nxt   = rem_dec;
              fill_nxt  = '0;
              seen_nxt  = 1'b0;
              tick_nxt  = '0;
              phase_nxt = '0;
              res_valid = 1'b1;
              if (rem_dec != 8'd0) begin
                res_event = crw_pkg::EV_SEND;
                res_left  = rem_dec;
              end else begin
                busy_nxt  = 1'b0;
                res_event = crw_pkg::EV_FAIL;
              end
            end else if (phase_inc >= {1'b0, check_period_r}) begin
              phase_nxt = '0;
              if (seen_r || (kw_n == '0)) begin
                busy_nxt  = 1'b0;
                fill_nxt  = '0;
                seen_nxt  = 1'b0;
                tick_nxt  = '0;
                res_valid = 1'b1;
                res_event = crw_pkg::EV_OK;
                res_left  = rem_r;
              end
            end else begin
              phase_nxt = phase_inc[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      seen_r  <= 1'b0;
      tick_r  <= '0;
      phase_r <= '0;
      rem_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      seen_r  <= seen_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Window bytes are only trusted below the fill count
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_event_r <= res_event;
      out_left_r  <= res_left;
    end
  end

  // Checks
  a_busy_has_attempts: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r != 8'd0)
    else $error("busy exchange with no attempts left");

  a_idle_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (fill_r == '0 && !seen_r && tick_r == '0))
    else $error("idle block holds attempt state");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN_N))
    else $error("window fill beyond depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == crw_pkg::EV_FAIL) |-> out_left_r == 8'd0)
    else $error("failure result with attempts left");

  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == crw_pkg::EV_SEND) |-> busy_r)
    else $error("send result while exchange idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && out_stall) |=> in_valid_r)
    else $error("transaction lost while result stalled");

endmodule

`default_nettype wire
